>>> rtl/sem_pkg.sv
package sem_pkg;

	// Field widths of the stream and configuration ports.
	localparam int PIXEL_W = 8;
	localparam int OUT_ROW_W = 12;
	localparam int OUT_COL_W = 10;
	localparam int MAG_W = 8;
	localparam int OUT_FIELDS_W = OUT_ROW_W + OUT_COL_W + MAG_W;
	localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 13;
	localparam int FRAME_WIDTH_W = 11;
	localparam int FRAME_HEIGHT_W = 13;

	// Register indexes on the configuration channel.
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam int RESET_FRAME_WIDTH = 640;
	localparam int RESET_FRAME_HEIGHT = 480;
	localparam int MIN_FRAME = 3;

	// One line store word holds the pixel one row up (high byte) and two rows up (low byte).
	localparam int LINE_W = 2 * PIXEL_W;
	localparam int WIN_W = 3 * PIXEL_W;

	// |gx| and |gy| never exceed 1020, the sum of squares needs one bit more than a square.
	localparam int GRAD_W = 10;
	localparam int SUMSQ_W = 2 * GRAD_W + 1;

	// Square root datapath: 8 root bits from a 16-bit radicand.
	localparam int ROOT_W = MAG_W;
	localparam int RAD_W = 2 * ROOT_W;
	localparam logic [RAD_W-1:0] RAD_MAX = '1;

	// Result slots that one input pixel can cause, in emission order.
	localparam int RES_N = 3;
	localparam int RES_INNER = 0;
	localparam int RES_RIGHT = 1;
	localparam int RES_BOTTOM = 2;

	typedef struct packed {
		logic [OUT_ROW_W-1:0] row;
		logic [OUT_COL_W-1:0] col;
		logic [RES_N-1:0] mask;
		logic interior;
	} tag_t;

	typedef struct packed {
		logic [OUT_ROW_W-1:0] row;
		logic [OUT_COL_W-1:0] col;
		logic [MAG_W-1:0] mag;
		logic last;
	} result_t;

endpackage

>>> rtl/sem_line_store.sv
module sem_line_store #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic rd_en,
	input logic [AW-1:0] rd_addr,
	output logic [sem_pkg::LINE_W-1:0] rd_data,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input logic [sem_pkg::LINE_W-1:0] wr_data
);

	logic [sem_pkg::LINE_W-1:0] mem [DEPTH];
	logic [sem_pkg::LINE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/sem_sqrt_cell.sv
module sem_sqrt_cell #(
	parameter int BIT = 0
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic [sem_pkg::RAD_W-1:0] rem_in,
	input logic [sem_pkg::ROOT_W-1:0] root_in,
	input sem_pkg::tag_t tag_in,
	output logic [sem_pkg::RAD_W-1:0] rem_out,
	output logic [sem_pkg::ROOT_W-1:0] root_out,
	output sem_pkg::tag_t tag_out
);

	localparam int TRIAL_W = sem_pkg::RAD_W + 1;

	logic [TRIAL_W-1:0] trial;
	logic [TRIAL_W-1:0] rem_ext;
	logic fits;
	logic [sem_pkg::RAD_W-1:0] rem_q;
	logic [sem_pkg::ROOT_W-1:0] root_q;
	sem_pkg::tag_t tag_q;

	// Setting this root bit adds 2*root*b + b*b to the square.
	always_comb begin
		rem_ext = TRIAL_W'(rem_in);
		trial = (TRIAL_W'(root_in) << (BIT + 1)) + (TRIAL_W'(1) << (2 * BIT));
		fits = (rem_ext >= trial);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= fits ? sem_pkg::RAD_W'(rem_ext - trial) : rem_in;
			root_q <= fits ? (root_in | (sem_pkg::ROOT_W'(1) << BIT)) : root_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (en) begin
			tag_q <= tag_in;
		end
	end

	assign rem_out = rem_q;
	assign root_out = root_q;
	assign tag_out = tag_q;

endmodule

>>> rtl/sem_emit.sv
module sem_emit (
	input logic clk,
	input logic arst_n,
	input sem_pkg::tag_t tag_in,
	input logic [sem_pkg::MAG_W-1:0] mag_in,
	output logic take,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [sem_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic m_axis_tlast
);

	logic [sem_pkg::RES_N-1:0] pend_q;
	logic [sem_pkg::RES_N-1:0] lowest;
	logic [sem_pkg::RES_N-1:0] rest;
	logic has;
	logic push;
	sem_pkg::tag_t hold_q;
	logic [sem_pkg::MAG_W-1:0] mag_q;
	sem_pkg::result_t item;
	logic out_valid_q;
	sem_pkg::result_t out_q;
	logic skid_valid_q;
	sem_pkg::result_t skid_q;
	logic head_free;

	// The held item gives its pending results lowest slot first.
	always_comb begin
		lowest = pend_q & (~pend_q + sem_pkg::RES_N'(1));
		rest = pend_q & ~lowest;
		has = (pend_q != '0);
		push = has && !skid_valid_q;
		take = !has || (push && (rest == '0));
		head_free = !out_valid_q || m_axis_tready;

		item.row = hold_q.row;
		item.col = hold_q.col;
		item.mag = '0;
		item.last = (rest == '0);
		if (lowest[sem_pkg::RES_INNER]) begin
			item.row = hold_q.row - sem_pkg::OUT_ROW_W'(1);
			item.col = hold_q.col - sem_pkg::OUT_COL_W'(1);
			item.mag = hold_q.interior ? mag_q : '0;
		end else if (lowest[sem_pkg::RES_RIGHT]) begin
			item.row = hold_q.row - sem_pkg::OUT_ROW_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (take) begin
			pend_q <= tag_in.mask;
		end else if (push) begin
			pend_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			hold_q <= tag_in;
			mag_q <= mag_in;
		end
	end

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (head_free) begin
			out_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (head_free) begin
			out_q <= skid_valid_q ? skid_q : item;
		end else if (push) begin
			skid_q <= item;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {sem_pkg::OUT_PAD_W'(0), out_q.mag, out_q.col, out_q.row};
	assign m_axis_tlast = out_q.last;

	a_skid_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a result while the output register is empty");

	a_pend_held: assert property (@(posedge clk) disable iff (!arst_n)
		(has && !take && !push) |=> (pend_q == $past(pend_q)))
		else $error("pending results changed while emission was blocked");

	a_pend_one_less: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !take) |=> ($countones(pend_q) == $countones($past(pend_q)) - 1))
		else $error("an emitted result was not retired from the pending set");

endmodule

>>> rtl/sobel_edge_magnitude_core.sv
// Streaming 3x3 Sobel edge magnitude.
// Pixels enter on s_axis in raster order, one 8-bit grey level per request in tdata.
// Each result leaves on m_axis with its row, column and magnitude min(floor(sqrt(gx^2+gy^2)),255);
// border pixels give zero. tlast marks the last result caused by one input pixel.
// The cfg channel writes frame_width (index 0) and frame_height (index 1); values outside
// 3..MAX_WIDTH and 3..MAX_HEIGHT are clamped. A write to either restarts the frame at row 0,
// column 0; the user must issue it only while the core is idle, which the core does not enforce.
// cfg_ready is always high.
// A result reaches m_axis through the read of the line store, the gradient and square stages,
// the eight square-root cells and the emitter's hold and output registers.
// Throughput: one pixel per cycle while each pixel causes at most one result and m_axis takes
// results. Pixels in the last column below row 0 or in the last row right of column 0 cause
// two or three results and hold the input while the emitter hands them out one per cycle.
// If m_axis stalls, the output register and its skid entry absorb two results, after which the
// pipeline and s_axis_tready stop; s_axis_tready never depends on m_axis_tready directly.
// Reset sets 640x480, clears the position counters, the window and all control state. The line
// stores are not cleared; entries that were never written are only read for border pixels.
module sobel_edge_magnitude_core #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [sem_pkg::PIXEL_W-1:0] s_axis_tdata, // [7:0] pixel
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// [11:0] out_row, [21:12] out_col, [29:22] magnitude, [31:30] zero
	output logic [sem_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic m_axis_tlast, // last_of_run
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [sem_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [sem_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int WIDTH_LAST_RST =
		((sem_pkg::RESET_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : sem_pkg::RESET_FRAME_WIDTH) - 1;
	localparam int HEIGHT_LAST_RST =
		((sem_pkg::RESET_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : sem_pkg::RESET_FRAME_HEIGHT) - 1;
	localparam int GSUM_W = sem_pkg::GRAD_W + 2;
	localparam int PW = sem_pkg::PIXEL_W;

	// Handshake and configuration.
	logic adv;
	logic acc;
	logic cfg_wr;
	logic cfg_hit_w;
	logic cfg_hit_h;
	logic [sem_pkg::FRAME_WIDTH_W-1:0] fw;
	logic [sem_pkg::FRAME_HEIGHT_W-1:0] fh;
	logic [COL_W-1:0] width_last_d;
	logic [ROW_W-1:0] height_last_d;
	logic [COL_W-1:0] width_last_q;
	logic [ROW_W-1:0] height_last_q;

	// Position of the next input pixel.
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic col_last;
	logic row_last;
	sem_pkg::tag_t tag_d;

	// Stage 1: accepted pixel and the line store read.
	logic valid_s1;
	logic [PW-1:0] pixel_s1;
	logic [COL_W-1:0] col_s1;
	sem_pkg::tag_t tag_s1;
	logic [sem_pkg::LINE_W-1:0] line_rd_s1;
	logic line_we;

	// 3x3 window: two stored columns plus the arriving one.
	logic [sem_pkg::WIN_W-1:0] window_left_q;
	logic [sem_pkg::WIN_W-1:0] window_mid_q;
	logic [sem_pkg::WIN_W-1:0] window_new;
	logic [sem_pkg::GRAD_W-1:0] abs_gx;
	logic [sem_pkg::GRAD_W-1:0] abs_gy;

	// Stage 2: gradient magnitudes. Stage 3: saturated radicand.
	logic [sem_pkg::GRAD_W-1:0] ax_s2;
	logic [sem_pkg::GRAD_W-1:0] ay_s2;
	sem_pkg::tag_t tag_s2;
	logic [2*sem_pkg::GRAD_W-1:0] sq_x;
	logic [2*sem_pkg::GRAD_W-1:0] sq_y;
	logic [sem_pkg::SUMSQ_W-1:0] sum_sq;
	logic [sem_pkg::RAD_W-1:0] rad_s3;
	sem_pkg::tag_t tag_s3;

	// Square root cell chain, one root bit per cell, most significant first.
	logic [sem_pkg::RAD_W-1:0] rem_c [sem_pkg::ROOT_W+1];
	logic [sem_pkg::ROOT_W-1:0] root_c [sem_pkg::ROOT_W+1];
	sem_pkg::tag_t tag_c [sem_pkg::ROOT_W+1];

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign s_axis_tready = adv;
	assign acc = s_axis_tvalid && adv;

	// Clamp the written frame size and keep it as the index of the last column and row.
	always_comb begin
		fw = cfg_data[sem_pkg::FRAME_WIDTH_W-1:0];
		fh = cfg_data[sem_pkg::FRAME_HEIGHT_W-1:0];
		if (fw < sem_pkg::FRAME_WIDTH_W'(sem_pkg::MIN_FRAME)) begin
			width_last_d = COL_W'(sem_pkg::MIN_FRAME - 1);
		end else if (32'(fw) > MAX_WIDTH) begin
			width_last_d = COL_W'(MAX_WIDTH - 1);
		end else begin
			width_last_d = COL_W'(fw - sem_pkg::FRAME_WIDTH_W'(1));
		end
		if (fh < sem_pkg::FRAME_HEIGHT_W'(sem_pkg::MIN_FRAME)) begin
			height_last_d = ROW_W'(sem_pkg::MIN_FRAME - 1);
		end else if (32'(fh) > MAX_HEIGHT) begin
			height_last_d = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			height_last_d = ROW_W'(fh - sem_pkg::FRAME_HEIGHT_W'(1));
		end

		cfg_hit_w = 1'b0;
		cfg_hit_h = 1'b0;
		unique case (cfg_index)
			sem_pkg::REG_FRAME_WIDTH: cfg_hit_w = cfg_wr;
			sem_pkg::REG_FRAME_HEIGHT: cfg_hit_h = cfg_wr;
			default: ;
		endcase
	end

	// Which results this pixel causes: the completed neighbor up and to the left, interior or on
	// the left/top border; the right border pixel of the row above; the pixel itself on the bottom row.
	always_comb begin
		col_last = (col_q >= width_last_q);
		row_last = (row_q >= height_last_q);
		tag_d.row = sem_pkg::OUT_ROW_W'(row_q);
		tag_d.col = sem_pkg::OUT_COL_W'(col_q);
		tag_d.mask[sem_pkg::RES_INNER] = (row_q != '0) && (col_q != '0);
		tag_d.mask[sem_pkg::RES_RIGHT] = (row_q != '0) && col_last;
		tag_d.mask[sem_pkg::RES_BOTTOM] = row_last;
		tag_d.interior = (row_q > ROW_W'(1)) && (col_q > COL_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_last_q <= COL_W'(WIDTH_LAST_RST);
			height_last_q <= ROW_W'(HEIGHT_LAST_RST);
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_hit_w || cfg_hit_h) begin
			if (cfg_hit_w) begin
				width_last_q <= width_last_d;
			end
			if (cfg_hit_h) begin
				height_last_q <= height_last_d;
			end
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// The store is read at acceptance and rewritten when the pixel leaves stage 1; the same
	// column is not read again before that, as a row is at least three pixels long.
	assign line_we = adv && valid_s1;

	sem_line_store #(
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk(clk),
		.rd_en(acc),
		.rd_addr(col_q),
		.rd_data(line_rd_s1),
		.wr_en(line_we),
		.wr_addr(col_s1),
		.wr_data({pixel_s1, line_rd_s1[sem_pkg::LINE_W-1:PW]})
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pixel_s1 <= s_axis_tdata;
			col_s1 <= col_q;
			tag_s1 <= tag_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_left_q <= '0;
			window_mid_q <= '0;
		end else if (line_we) begin
			window_left_q <= window_mid_q;
			window_mid_q <= window_new;
		end
	end

	// Lane 0 of a column is two rows up, lane 1 one row up, lane 2 the current row.
	always_comb begin
		logic signed [GSUM_W-1:0] l0, l1, l2, m0, m2, r0, r1, r2, gx, gy;
		window_new = {pixel_s1, line_rd_s1};
		l0 = GSUM_W'(window_left_q[0*PW +: PW]);
		l1 = GSUM_W'(window_left_q[1*PW +: PW]);
		l2 = GSUM_W'(window_left_q[2*PW +: PW]);
		m0 = GSUM_W'(window_mid_q[0*PW +: PW]);
		m2 = GSUM_W'(window_mid_q[2*PW +: PW]);
		r0 = GSUM_W'(window_new[0*PW +: PW]);
		r1 = GSUM_W'(window_new[1*PW +: PW]);
		r2 = GSUM_W'(window_new[2*PW +: PW]);
		gx = (r0 - l0) + (r1 - l1) + (r1 - l1) + (r2 - l2);
		gy = (l2 + m2 + m2 + r2) - (l0 + m0 + m0 + r0);
		abs_gx = sem_pkg::GRAD_W'(gx[GSUM_W-1] ? -gx : gx);
		abs_gy = sem_pkg::GRAD_W'(gy[GSUM_W-1] ? -gy : gy);
	end

	always_comb begin
		sq_x = ax_s2 * ax_s2;
		sq_y = ay_s2 * ay_s2;
		sum_sq = {1'b0, sq_x} + {1'b0, sq_y};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s2 <= abs_gx;
			ay_s2 <= abs_gy;
			// Any sum of 65536 or more has a root of 256 or more and saturates to 255,
			// which is also the root of the all-ones radicand.
			rad_s3 <= (sum_sq[sem_pkg::SUMSQ_W-1:sem_pkg::RAD_W] != '0) ?
				sem_pkg::RAD_MAX : sum_sq[sem_pkg::RAD_W-1:0];
		end
	end

	// A bubble in stage 1 enters stage 2 with no results pending.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (adv) begin
			tag_s2 <= valid_s1 ? tag_s1 : '0;
			tag_s3 <= tag_s2;
		end
	end

	assign rem_c[0] = rad_s3;
	assign root_c[0] = '0;
	assign tag_c[0] = tag_s3;

	for (genvar i = 0; i < sem_pkg::ROOT_W; i++) begin : g_cell
		sem_sqrt_cell #(
			.BIT(sem_pkg::ROOT_W - 1 - i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(adv),
			.rem_in(rem_c[i]),
			.root_in(root_c[i]),
			.tag_in(tag_c[i]),
			.rem_out(rem_c[i+1]),
			.root_out(root_c[i+1]),
			.tag_out(tag_c[i+1])
		);
	end

	// The whole pipeline moves whenever the emitter takes its next item.
	sem_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.tag_in(tag_c[sem_pkg::ROOT_W]),
		.mag_in(root_c[sem_pkg::ROOT_W]),
		.take(adv),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	a_position_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= width_last_q) && (row_q <= height_last_q))
		else $error("pixel position left the configured frame");

	a_line_store_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(line_we && acc) |-> (col_s1 != col_q))
		else $error("line store read and write hit the same column in one cycle");

	a_root_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_c[sem_pkg::ROOT_W].mask[sem_pkg::RES_INNER] && tag_c[sem_pkg::ROOT_W].interior) |->
		((sem_pkg::RAD_W + 1)'(rem_c[sem_pkg::ROOT_W]) <=
			((sem_pkg::RAD_W + 1)'(root_c[sem_pkg::ROOT_W]) << 1)))
		else $error("square root remainder exceeds twice the root");

endmodule

>>> tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 4;
	localparam int LINE_DEPTH = 1024;
	localparam int ROW_LIMIT = 4096;
	localparam int RANDOM_ITEMS = 300;
	localparam int MAX_GAP = 17;
	localparam int MAX_REPORTS = 10;
	// The drain leaves ample margin for results still passing through the core's pipeline.
	localparam int DRAIN_CYCLES = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [sem_pkg::MAG_W-1:0] MAG_SATURATED = '1;

	// Indexes that decode to no register; a write to them must change nothing.
	localparam logic [sem_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [sem_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

	// How a side spaces its requests: random gaps, back to back, or mostly back to back.
	typedef enum int {PACE_RANDOM, PACE_BURST, PACE_SPARSE} pace_t;

	// Kinds of picture content used for random frames.
	typedef enum int {IMG_NOISE, IMG_SMOOTH, IMG_BINARY} image_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [sem_pkg::PIXEL_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [sem_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [sem_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [sem_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Pixels waiting to be offered, and the edge results the core still owes us.
	logic [sem_pkg::PIXEL_W-1:0] pixel_queue [$];
	sem_pkg::result_t due_edges [$];
	int pixels_queued = 0;
	int pixels_accepted = 0;
	int fail_count = 0;
	int quiet_cycles = 0;
	int src_wait = 0;
	int sink_wait = 0;
	pace_t src_pace = PACE_RANDOM;
	pace_t sink_pace = PACE_RANDOM;

	// Our own copy of the core's state: registers, line stores, window and position.
	logic [sem_pkg::FRAME_WIDTH_W-1:0] width_reg;
	logic [sem_pkg::FRAME_HEIGHT_W-1:0] height_reg;
	logic [sem_pkg::PIXEL_W-1:0] line_above [LINE_DEPTH];
	logic [sem_pkg::PIXEL_W-1:0] line_two_above [LINE_DEPTH];
	logic [sem_pkg::WIN_W-1:0] win_left;
	logic [sem_pkg::WIN_W-1:0] win_mid;
	int unsigned cur_row;
	int unsigned cur_col;

	sobel_edge_magnitude_core #(
		.MAX_WIDTH(LINE_DEPTH),
		.MAX_HEIGHT(ROW_LIMIT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int draw_wait(input pace_t pace);
		case (pace)
			PACE_RANDOM: return $urandom_range(0, MAX_GAP);
			PACE_BURST: return 0;
			default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_GAP) : 0;
		endcase
	endfunction

	// Sobel magnitude of a 3x3 window given as three columns. In each column the low byte
	// is the row two up, the middle byte the row one up and the high byte the current row.
	// The magnitude is the integer square root of gx^2+gy^2, saturated at 255.
	function automatic logic [sem_pkg::MAG_W-1:0] gradient_magnitude(
			input logic [sem_pkg::WIN_W-1:0] l, input logic [sem_pkg::WIN_W-1:0] m,
			input logic [sem_pkg::WIN_W-1:0] r);
		int lt, lm, lb, mt, mb, rt, rm, rb;
		int gx, gy, sum_sq, root;
		lt = l[sem_pkg::PIXEL_W-1:0];
		lm = l[2*sem_pkg::PIXEL_W-1:sem_pkg::PIXEL_W];
		lb = l[sem_pkg::WIN_W-1:2*sem_pkg::PIXEL_W];
		mt = m[sem_pkg::PIXEL_W-1:0];
		mb = m[sem_pkg::WIN_W-1:2*sem_pkg::PIXEL_W];
		rt = r[sem_pkg::PIXEL_W-1:0];
		rm = r[2*sem_pkg::PIXEL_W-1:sem_pkg::PIXEL_W];
		rb = r[sem_pkg::WIN_W-1:2*sem_pkg::PIXEL_W];
		gx = (rt - lt) + 2 * (rm - lm) + (rb - lb);
		gy = (lb + 2 * mb + rb) - (lt + 2 * mt + rt);
		sum_sq = gx * gx + gy * gy;
		if (sum_sq >= 65536)
			return MAG_SATURATED;
		root = 0;
		for (int b = 128; b > 0; b >>= 1)
			if ((root + b) * (root + b) <= sum_sq)
				root += b;
		return sem_pkg::MAG_W'(root);
	endfunction

	// Advance the state copy by one accepted pixel and queue the results it causes:
	// the interior (or left/top border) pixel up and to the left, the right border pixel
	// of the row above when the column is the last, and the pixel itself on the last row.
	function automatic void predict_edges(input logic [sem_pkg::PIXEL_W-1:0] pix);
		int unsigned w, h, n;
		logic c_last, r_last;
		logic [sem_pkg::PIXEL_W-1:0] above, two_above;
		logic [sem_pkg::WIN_W-1:0] arriving;
		sem_pkg::result_t batch [sem_pkg::RES_N];
		w = (width_reg < sem_pkg::MIN_FRAME) ? sem_pkg::MIN_FRAME :
			(width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg;
		h = (height_reg < sem_pkg::MIN_FRAME) ? sem_pkg::MIN_FRAME :
			(height_reg > ROW_LIMIT) ? ROW_LIMIT : height_reg;
		c_last = (cur_col >= w - 1);
		r_last = (cur_row >= h - 1);
		above = line_above[cur_col];
		two_above = line_two_above[cur_col];
		line_two_above[cur_col] = above;
		line_above[cur_col] = pix;
		arriving = {pix, above, two_above};
		n = 0;
		if (cur_row >= 1 && cur_col >= 1) begin
			batch[n].row = sem_pkg::OUT_ROW_W'(cur_row - 1);
			batch[n].col = sem_pkg::OUT_COL_W'(cur_col - 1);
			batch[n].mag = (cur_row >= 2 && cur_col >= 2) ?
				gradient_magnitude(win_left, win_mid, arriving) : '0;
			n++;
		end
		if (cur_row >= 1 && c_last) begin
			batch[n].row = sem_pkg::OUT_ROW_W'(cur_row - 1);
			batch[n].col = sem_pkg::OUT_COL_W'(cur_col);
			batch[n].mag = '0;
			n++;
		end
		if (r_last) begin
			batch[n].row = sem_pkg::OUT_ROW_W'(cur_row);
			batch[n].col = sem_pkg::OUT_COL_W'(cur_col);
			batch[n].mag = '0;
			n++;
		end
		for (int i = 0; i < n; i++) begin
			batch[i].last = (i == n - 1);
			due_edges.push_back(batch[i]);
		end
		win_left = win_mid;
		win_mid = arriving;
		if (c_last) begin
			cur_col = 0;
			cur_row = r_last ? 0 : cur_row + 1;
		end else begin
			cur_col = cur_col + 1;
		end
	endfunction

	// Pixel driver. A pixel request is held until accepted; after each acceptance the next
	// one waits a drawn number of cycles before it is offered.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_edges(s_axis_tdata);
				pixels_accepted++;
				src_wait = draw_wait(src_pace);
			end
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (src_wait > 0) begin
					src_wait--;
					s_axis_tvalid <= 1'b0;
				end else if (pixel_queue.size() > 0) begin
					s_axis_tdata <= pixel_queue.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor. Every accepted result is matched against the oldest one owed; the
	// receiver then stalls for a drawn number of cycles before taking the next.
	always @(posedge clk or negedge arst_n) begin : edge_monitor
		sem_pkg::result_t want;
		logic [sem_pkg::OUT_ROW_W-1:0] got_row;
		logic [sem_pkg::OUT_COL_W-1:0] got_col;
		logic [sem_pkg::MAG_W-1:0] got_mag;
		logic [sem_pkg::OUT_PAD_W-1:0] got_pad;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_row = m_axis_tdata[sem_pkg::OUT_ROW_W-1:0];
				got_col = m_axis_tdata[sem_pkg::OUT_ROW_W +: sem_pkg::OUT_COL_W];
				got_mag = m_axis_tdata[sem_pkg::OUT_ROW_W + sem_pkg::OUT_COL_W +: sem_pkg::MAG_W];
				got_pad = m_axis_tdata[sem_pkg::OUT_TDATA_W-1 -: sem_pkg::OUT_PAD_W];
				if (due_edges.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("unexpected result: row %0d col %0d magnitude %0d last %0b",
							got_row, got_col, got_mag, m_axis_tlast);
				end else begin
					want = due_edges.pop_front();
					if (got_row != want.row || got_col != want.col || got_mag != want.mag ||
							m_axis_tlast != want.last || got_pad != '0) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS) begin
							$write("mismatch: expected row %0d col %0d magnitude %0d last %0b,",
								want.row, want.col, want.mag, want.last);
							$display(" got row %0d col %0d magnitude %0d last %0b pad %0h",
								got_row, got_col, got_mag, m_axis_tlast, got_pad);
						end
					end
				end
				sink_wait = draw_wait(sink_pace);
			end
			if (sink_wait > 0) begin
				sink_wait--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: the run is stuck if no request of any kind completes for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("sobel_edge_magnitude_core verification failed");
				$finish;
			end
		end
	end

	function automatic void send_pixel(input logic [sem_pkg::PIXEL_W-1:0] pix);
		pixel_queue.push_back(pix);
		pixels_queued++;
	endfunction

	task automatic send_random_pixels(input int count, input image_t kind);
		int base;
		base = $urandom_range(0, 230);
		for (int i = 0; i < count; i++) begin
			case (kind)
				IMG_NOISE: send_pixel(sem_pkg::PIXEL_W'($urandom_range(0, 255)));
				IMG_SMOOTH: send_pixel(sem_pkg::PIXEL_W'(base + $urandom_range(0, 25)));
				default: send_pixel($urandom_range(0, 1) ? 8'd255 : 8'd0);
			endcase
		end
	endtask

	// Wait until every pixel has been taken and every owed result has come, then let the
	// pipeline run dry, since pixels on row 0 leave work in flight that shows no result.
	task automatic wait_idle();
		do @(posedge clk);
		while (pixels_accepted != pixels_queued || due_edges.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One configuration request. A write to a known register also restarts the frame.
	task automatic write_reg(input logic [sem_pkg::CFG_INDEX_W-1:0] idx,
			input logic [sem_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			sem_pkg::REG_FRAME_WIDTH: begin
				width_reg = val[sem_pkg::FRAME_WIDTH_W-1:0];
				cur_row = 0;
				cur_col = 0;
			end
			sem_pkg::REG_FRAME_HEIGHT: begin
				height_reg = val[sem_pkg::FRAME_HEIGHT_W-1:0];
				cur_row = 0;
				cur_col = 0;
			end
			default: ;
		endcase
	endtask

	initial begin
		int w, h, eff_w, eff_h, frames, random_count;
		image_t kind;
		width_reg = sem_pkg::FRAME_WIDTH_W'(sem_pkg::RESET_FRAME_WIDTH);
		height_reg = sem_pkg::FRAME_HEIGHT_W'(sem_pkg::RESET_FRAME_HEIGHT);
		foreach (line_above[i]) begin
			line_above[i] = '0;
			line_two_above[i] = '0;
		end
		win_left = '0;
		win_mid = '0;
		cur_row = 0;
		cur_col = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// A couple of pixels under the reset frame size; on row 0 they cause no result.
		send_pixel(8'd0);
		send_pixel(8'd255);
		wait_idle();

		// Smallest frame with a full-scale vertical edge: the single interior pixel saturates.
		write_reg(sem_pkg::REG_FRAME_WIDTH, 13'd3);
		write_reg(sem_pkg::REG_FRAME_HEIGHT, 13'd3);
		for (int i = 0; i < 3; i++) begin
			send_pixel(8'd0);
			send_pixel(8'd0);
			send_pixel(8'd255);
		end
		wait_idle();

		// Sizes below the minimum clamp to 3x3. The frame is split by a write to an
		// unused index, which must not restart it; the interior magnitude stays unsaturated.
		write_reg(sem_pkg::REG_FRAME_WIDTH, 13'd0);
		write_reg(sem_pkg::REG_FRAME_HEIGHT, 13'd2);
		send_pixel(8'd5);
		send_pixel(8'd9);
		send_pixel(8'd12);
		send_pixel(8'd3);
		wait_idle();
		write_reg(REG_SPARE_A, '1);
		write_reg(REG_SPARE_B, 13'h0AAA);
		send_pixel(8'd7);
		send_pixel(8'd20);
		send_pixel(8'd0);
		send_pixel(8'd4);
		send_pixel(8'd6);
		wait_idle();

		// A frame cut short by a register write, which starts the next frame at row 0.
		send_pixel(8'd255);
		send_pixel(8'd128);
		send_pixel(8'd1);
		send_pixel(8'd254);
		wait_idle();
		write_reg(sem_pkg::REG_FRAME_HEIGHT, 13'd3);

		// Random phases: a new frame size, one or two whole frames back to back, and now and
		// then a broken frame left unfinished for the next phase's writes to cut off.
		random_count = 0;
		while (random_count < RANDOM_ITEMS) begin
			src_pace = pace_t'($urandom_range(0, 2));
			sink_pace = pace_t'($urandom_range(0, 2));
			kind = image_t'($urandom_range(0, 2));
			case ($urandom_range(0, 9))
				0: w = $urandom_range(0, 2);
				1: w = $urandom_range(13, 24);
				default: w = $urandom_range(3, 12);
			endcase
			if (w > 12)
				h = $urandom_range(3, 4);
			else
				case ($urandom_range(0, 7))
					0: h = $urandom_range(0, 2);
					1: h = $urandom_range(7, 10);
					default: h = $urandom_range(3, 6);
				endcase
			eff_w = (w < sem_pkg::MIN_FRAME) ? sem_pkg::MIN_FRAME : w;
			eff_h = (h < sem_pkg::MIN_FRAME) ? sem_pkg::MIN_FRAME : h;
			// Bits above the width field are written too; the register keeps only 11 bits.
			if ($urandom_range(0, 1)) begin
				write_reg(sem_pkg::REG_FRAME_WIDTH,
					sem_pkg::CFG_DATA_W'(w | ($urandom_range(0, 3) << 11)));
				write_reg(sem_pkg::REG_FRAME_HEIGHT, sem_pkg::CFG_DATA_W'(h));
			end else begin
				write_reg(sem_pkg::REG_FRAME_HEIGHT, sem_pkg::CFG_DATA_W'(h));
				write_reg(sem_pkg::REG_FRAME_WIDTH,
					sem_pkg::CFG_DATA_W'(w | ($urandom_range(0, 3) << 11)));
			end
			if ($urandom_range(0, 5) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
					sem_pkg::CFG_DATA_W'($urandom));
			frames = $urandom_range(1, 2);
			for (int f = 0; f < frames; f++) begin
				send_random_pixels(eff_w * eff_h, kind);
				random_count += eff_w * eff_h;
			end
			if ($urandom_range(0, 3) == 0) begin
				frames = $urandom_range(1, eff_w * eff_h - 1);
				send_random_pixels(frames, kind);
				random_count += frames;
			end
			wait_idle();
		end

		// Tallest frame, written above the maximum so it clamps, with a few narrow rows.
		src_pace = PACE_SPARSE;
		sink_pace = PACE_RANDOM;
		write_reg(sem_pkg::REG_FRAME_WIDTH, 13'd3);
		write_reg(sem_pkg::REG_FRAME_HEIGHT, 13'h1FFF);
		send_random_pixels(15, IMG_NOISE);
		wait_idle();

		if (fail_count == 0)
			$display("sobel_edge_magnitude_core verification clean");
		else
			$display("sobel_edge_magnitude_core verification failed");
		$finish;
	end

endmodule
